>>> hw/rtl/swfts_pkg.sv
// Package for the sliding-window frame statistics core.
// Widths, sequencer states and shared constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package swfts_pkg;
  localparam int unsigned RingDepthDef = 1024;
  localparam logic [31:0] WindowReset  = 32'd20000000;
  localparam logic [63:0] FpsScale     = 64'd256000000;
  localparam int unsigned DivW         = 64;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_EVRD   = 13'b0000000000010,
    S_EVAPP  = 13'b0000000000100,
    S_PRVRD  = 13'b0000000001000,
    S_STORE  = 13'b0000000010000,
    S_AGERD  = 13'b0000000100000,
    S_AGECHK = 13'b0000001000000,
    S_SCNRD  = 13'b0000010000000,
    S_SCNACC = 13'b0000100000000,
    S_LATRD  = 13'b0001000000000,
    S_DIVGO  = 13'b0010000000000,
    S_DIVWT  = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } seq_state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage
`default_nettype wire

>>> hw/rtl/sliding_window_frame_time_stats_core.sv
// Sliding time-window frame statistics core.
// The five divisions share one bit-serial divider; a zero divisor skips the bit-serial loop.
// Throughput: one item at a time; in_ready_o is low while an item is being worked on.
// Reset (async, rst_ni low): window empty, window_us = 20000000; the ring
//   memory itself is not cleared, only the held count.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_frame_time_stats_core #(
  parameter int unsigned RING_DEPTH = swfts_pkg::RingDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [47:0] timestamp_us_i,
  input  wire logic [23:0] period_us_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             accepted_o,
  output logic             overflow_o,
  output logic [10:0]      sample_count_o,
  output logic [27:0]      current_fps_q8_o,
  output logic [23:0]      current_period_out_us_o,
  output logic [27:0]      min_fps_q8_o,
  output logic [27:0]      max_fps_q8_o,
  output logic [27:0]      average_fps_q8_o,
  output logic [23:0]      jitter_us_o
);
  import swfts_pkg::*;
  localparam int unsigned IdxW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(RING_DEPTH);

  // ring memory: time and period side by side, one read port
  logic [71:0] ring_mem [RING_DEPTH];
  logic [71:0] rd_q;
  logic        we;
  logic [IdxW-1:0] waddr, raddr;
  logic [71:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) ring_mem[waddr] <= wdata;
    rd_q <= ring_mem[raddr];
  end

  function automatic logic [IdxW-1:0] slot_f(logic [IdxW-1:0] base, logic [CntW-1:0] k);
    logic [CntW:0] s;
    s = {1'b0, base} + {1'b0, k};
    if (s >= (CntW+1)'(RING_DEPTH)) s = s - (CntW+1)'(RING_DEPTH);
    return s[IdxW-1:0];
  endfunction

  function automatic logic [23:0] absd_f(logic [23:0] a, logic [23:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  seq_state_e st_q;
  logic [31:0] win_q;
  logic [IdxW-1:0] old_q;
  logic [CntW-1:0] cnt_q, k_q;
  logic [33:0] ptot_q, ctot_q;
  logic [23:0] worst_q, best_q, prev_q, p_q, lat_q, leave_q;
  logic        stale_q, acc_q, ovf_q;
  logic        ev_pre_q;  // eviction runs before the store (full ring)
  logic [47:0] now_q;
  logic [2:0]  dsel_q;
  logic [DivW-1:0] dnum, dden, dquo;
  div_ctl_t    dctl;

  assign dctl.start = (st_q == S_DIVGO);
  assign dctl.busy  = (st_q == S_DIVWT);

  swfts_div u_div (
    .clk_i, .rst_ni, .start_i(dctl.start), .num_i(dnum), .den_i(dden),
    .done_o(dctl.done), .quo_o(dquo)
  );

  always_comb begin
    dnum = FpsScale;
    dden = '0;
    unique case (dsel_q)
      3'd0: dden = DivW'(rd_q[23:0]);  // newest period, still on the read port
      3'd1: dden = DivW'(worst_q);
      3'd2: dden = DivW'(best_q);
      3'd3: begin
        dnum = DivW'(cnt_q) * FpsScale;
        dden = DivW'(ptot_q);
      end
      3'd4: begin
        dnum = DivW'(ctot_q);
        dden = (cnt_q < CntW'(2)) ? '0 : DivW'(cnt_q - 1'b1);
      end
      default: dden = '0;
    endcase
  end

  assign in_ready_o = (st_q == S_IDLE) && !out_valid_o;

  always_comb begin
    we    = (st_q == S_STORE);
    waddr = slot_f(old_q, cnt_q);
    wdata = {now_q, p_q};
    raddr = old_q;
    priority case (1'b1)
      st_q == S_PRVRD: raddr = slot_f(old_q, cnt_q - 1'b1);
      st_q == S_EVRD:  raddr = slot_f(old_q, k_q);
      st_q == S_SCNRD: raddr = slot_f(old_q, k_q);
      st_q == S_LATRD: raddr = slot_f(old_q, cnt_q - 1'b1);
      default:         raddr = old_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; win_q <= WindowReset; old_q <= '0; cnt_q <= '0;
      ptot_q <= '0; ctot_q <= '0; worst_q <= '0; best_q <= '0; stale_q <= 1'b0;
      out_valid_o <= 1'b0; k_q <= '0; dsel_q <= '0; ev_pre_q <= 1'b0;
    end else begin
      if (cfg_we_i) win_q <= cfg_wdata_i;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (st_q)
        S_IDLE: if (in_valid_i && in_ready_o) begin
          now_q <= timestamp_us_i; p_q <= period_us_i;
          acc_q <= 1'b0; ovf_q <= 1'b0; ev_pre_q <= 1'b0;
          if (opcode_i) begin
            old_q <= '0; cnt_q <= '0; ptot_q <= '0; ctot_q <= '0;
            worst_q <= '0; best_q <= '0; stale_q <= 1'b0; st_q <= S_OUT;
          end else if (period_us_i == '0) begin
            st_q <= (cnt_q == '0) ? S_OUT : (stale_q ? S_SCNRD : S_LATRD);
            k_q <= '0;
          end else begin
            acc_q <= 1'b1;
            k_q <= '0;
            ovf_q <= (cnt_q >= Full);
            ev_pre_q <= (cnt_q >= Full);
            st_q <= (cnt_q >= Full) ? S_EVRD : (cnt_q == '0 ? S_STORE : S_PRVRD);
          end
        end
        // eviction: read oldest period, then its successor
        S_EVRD: begin
          if (k_q == '0) begin
            k_q <= CntW'(1);
          end else begin
            leave_q <= rd_q[23:0];
            st_q <= S_EVAPP;
          end
        end
        S_EVAPP: begin
          // rd_q now holds slot(1)
          if (cnt_q >= CntW'(2)) ctot_q <= ctot_q - 34'(absd_f(rd_q[23:0], leave_q));
          ptot_q <= ptot_q - 34'(leave_q);
          if (leave_q == worst_q || leave_q == best_q) stale_q <= 1'b1;
          old_q <= slot_f(old_q, CntW'(1));
          cnt_q <= cnt_q - 1'b1;
          k_q <= '0;
          if (ev_pre_q) begin
            ev_pre_q <= 1'b0; st_q <= S_PRVRD;
          end else st_q <= S_AGERD;
        end
        S_PRVRD: st_q <= S_STORE;
        S_STORE: begin
          if (cnt_q != '0) ctot_q <= ctot_q + 34'(absd_f(p_q, rd_q[23:0]));
          ptot_q <= ptot_q + 34'(p_q);
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == '0) begin
            worst_q <= p_q; best_q <= p_q; stale_q <= 1'b0;
          end else begin
            if (p_q > worst_q) worst_q <= p_q;
            if (p_q < best_q) best_q <= p_q;
          end
          st_q <= S_AGERD;
        end
        S_AGERD: st_q <= S_AGECHK;
        S_AGECHK: begin
          if (cnt_q == '0) begin
            ptot_q <= '0; ctot_q <= '0; worst_q <= '0; best_q <= '0;
            stale_q <= 1'b0; st_q <= S_OUT;
          end else if (now_q >= rd_q[71:24] &&
                       (now_q - rd_q[71:24]) > 48'(win_q)) begin
            k_q <= '0; st_q <= S_EVRD;
          end else begin
            k_q <= '0;
            st_q <= stale_q ? S_SCNRD : S_LATRD;
          end
        end
        // rescan: address k issued in SCNRD, data used in SCNACC
        S_SCNRD: st_q <= S_SCNACC;
        S_SCNACC: begin
          if (k_q == '0) begin
            worst_q <= rd_q[23:0]; best_q <= rd_q[23:0];
            ptot_q <= 34'(rd_q[23:0]); ctot_q <= '0;
          end else begin
            if (rd_q[23:0] > worst_q) worst_q <= rd_q[23:0];
            if (rd_q[23:0] < best_q) best_q <= rd_q[23:0];
            ptot_q <= ptot_q + 34'(rd_q[23:0]);
            ctot_q <= ctot_q + 34'(absd_f(rd_q[23:0], prev_q));
          end
          prev_q <= rd_q[23:0];
          if (k_q == cnt_q - 1'b1) begin
            stale_q <= 1'b0; st_q <= S_LATRD;
          end else begin
            k_q <= k_q + 1'b1; st_q <= S_SCNRD;
          end
        end
        S_LATRD: begin
          st_q <= S_DIVGO; dsel_q <= '0;
        end
        S_DIVGO: begin
          if (dsel_q == '0) lat_q <= rd_q[23:0];
          st_q <= S_DIVWT;
        end
        S_DIVWT: if (dctl.done) begin
          unique case (dsel_q)
            3'd0: current_fps_q8_o <= dquo[27:0];
            3'd1: min_fps_q8_o     <= dquo[27:0];
            3'd2: max_fps_q8_o     <= dquo[27:0];
            3'd3: average_fps_q8_o <= dquo[27:0];
            default: jitter_us_o   <= dquo[23:0];
          endcase
          if (dsel_q == 3'd4) st_q <= S_OUT;
          else begin
            dsel_q <= dsel_q + 1'b1; st_q <= S_DIVGO;
          end
        end
        S_OUT: begin
          accepted_o <= acc_q; overflow_o <= ovf_q;
          sample_count_o <= 11'(cnt_q);
          current_period_out_us_o <= lat_q;
          if (cnt_q == '0) begin
            current_fps_q8_o <= '0; min_fps_q8_o <= '0; max_fps_q8_o <= '0;
            average_fps_q8_o <= '0; jitter_us_o <= '0; current_period_out_us_o <= '0;
          end
          out_valid_o <= 1'b1;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/swfts_div.sv
// Radix-2 restoring divider with round-to-nearest, ties upward.
// One quotient bit per cycle; uses swfts_pkg for the width.
`timescale 1ns / 1ps
`default_nettype none
module swfts_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [swfts_pkg::DivW-1:0] num_i,
  input  wire logic [swfts_pkg::DivW-1:0] den_i,
  output logic                            done_o,
  output logic [swfts_pkg::DivW-1:0]      quo_o
);
  import swfts_pkg::*;
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] n_q, d_q, q_q, r_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DivW:0]   rsh;
  logic [DivW:0]   rsub;

  assign rsh  = {r_q, n_q[DivW-1]};
  assign rsub = rsh - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= (den_i != '0);
        done_o <= (den_i == '0);
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i + (den_i >> 1);
      d_q <= den_i;
      q_q <= '0;
      r_q <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[DivW-2:0], 1'b0};
      if (!rsub[DivW]) begin
        r_q <= rsub[DivW-1:0];
        q_q <= {q_q[DivW-2:0], 1'b1};
      end else begin
        r_q <= rsh[DivW-1:0];
        q_q <= {q_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign quo_o = (d_q == '0) ? '0 : q_q;
endmodule
`default_nettype wire

>>> test/tb_sliding_window_frame_time_stats_core.sv
// Testbench for sliding_window_frame_time_stats_core: directed and random frame events,
// each summary checked against an in-bench window model. Depends on swfts_pkg and the core.
`timescale 1ns / 1ps
module tb_sliding_window_frame_time_stats_core;
  import swfts_pkg::*;

  localparam int unsigned Depth = RingDepthDef;
  // Slowest item is a full-ring eviction run plus a rescan plus five divides;
  // the limit covers every item at that cost several times over.
  localparam longint unsigned CycleLimit = 40_000_000;
  localparam bit OpRecord = 1'b0;
  localparam bit OpClear  = 1'b1;

  typedef struct packed {
    logic        accepted;
    logic        overflow;
    logic [10:0] sample_count;
    logic [27:0] current_fps;
    logic [23:0] current_period;
    logic [27:0] min_fps;
    logic [27:0] max_fps;
    logic [27:0] average_fps;
    logic [23:0] jitter;
  } frame_stats_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = 1'b0;
  logic [47:0] timestamp_us_i = '0;
  logic [23:0] period_us_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        accepted_o, overflow_o;
  logic [10:0] sample_count_o;
  logic [27:0] current_fps_q8_o, min_fps_q8_o, max_fps_q8_o, average_fps_q8_o;
  logic [23:0] current_period_out_us_o, jitter_us_o;

  sliding_window_frame_time_stats_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .opcode_i, .timestamp_us_i, .period_us_i,
    .out_valid_o, .out_ready_i, .accepted_o, .overflow_o, .sample_count_o,
    .current_fps_q8_o, .current_period_out_us_o, .min_fps_q8_o, .max_fps_q8_o,
    .average_fps_q8_o, .jitter_us_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Window model state
  logic [47:0]     win_time [Depth];
  logic [23:0]     win_period [Depth];
  int unsigned     win_head;
  int unsigned     win_count;
  longint unsigned period_sum;
  longint unsigned change_sum;
  logic [23:0]     longest_period;
  logic [23:0]     shortest_period;
  bit              extremes_dirty;
  logic [31:0]     window_len;

  frame_stats_t    pending_stats[$];
  int unsigned     mismatches = 0;
  int unsigned     summaries_seen = 0;
  int unsigned     overflows_seen = 0;
  int unsigned     rescans_done = 0;
  longint unsigned cycle_count = 0;
  bit              no_gaps = 1'b0;
  logic [47:0]     now_us = '0;
  int unsigned     ready_hold = 0;

  function automatic int unsigned ring_slot(int unsigned k);
    return (win_head + k) % Depth;
  endfunction

  function automatic longint unsigned abs_delta(logic [23:0] a, logic [23:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Round to nearest, ties upward; zero divisor gives zero
  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    if (d == 0) return 0;
    return (n + d / 2) / d;
  endfunction

  function automatic void window_reset_sums();
    win_count = 0;
    period_sum = 0;
    change_sum = 0;
    longest_period = '0;
    shortest_period = '0;
    extremes_dirty = 1'b0;
  endfunction

  function automatic void drop_oldest();
    logic [23:0] leaving;
    leaving = win_period[ring_slot(0)];
    if (win_count >= 2) change_sum -= abs_delta(win_period[ring_slot(1)], leaving);
    period_sum -= leaving;
    if (leaving == longest_period || leaving == shortest_period) extremes_dirty = 1'b1;
    win_head = ring_slot(1);
    win_count--;
  endfunction

  function automatic void rebuild_extremes();
    logic [23:0] prev, p;
    extremes_dirty = 1'b0;
    period_sum = 0;
    change_sum = 0;
    rescans_done++;
    prev = win_period[ring_slot(0)];
    longest_period = prev;
    shortest_period = prev;
    for (int unsigned k = 0; k < win_count; k++) begin
      p = win_period[ring_slot(k)];
      if (p > longest_period) longest_period = p;
      if (p < shortest_period) shortest_period = p;
      period_sum += p;
      if (k > 0) change_sum += abs_delta(p, prev);
      prev = p;
    end
  endfunction

  // Applies one frame event to the model and returns the summary it produces
  function automatic frame_stats_t window_summary(bit op, logic [47:0] ts, logic [23:0] p);
    frame_stats_t s;
    logic [23:0] newest;
    s = '0;
    if (op == OpClear) begin
      win_head = 0;
      window_reset_sums();
    end else if (p != 0) begin
      s.accepted = 1'b1;
      if (win_count >= Depth) begin
        drop_oldest();
        s.overflow = 1'b1;
      end
      if (win_count > 0) change_sum += abs_delta(p, win_period[ring_slot(win_count - 1)]);
      win_time[ring_slot(win_count)] = ts;
      win_period[ring_slot(win_count)] = p;
      win_count++;
      period_sum += p;
      if (win_count == 1) begin
        longest_period = p;
        shortest_period = p;
        extremes_dirty = 1'b0;
      end else begin
        if (p > longest_period) longest_period = p;
        if (p < shortest_period) shortest_period = p;
      end
      // Age eviction; a sample stamped later than now never counts as old
      while (win_count > 0 && ts >= win_time[ring_slot(0)] &&
             ts - win_time[ring_slot(0)] > {16'd0, window_len})
        drop_oldest();
      if (win_count == 0) window_reset_sums();
    end
    s.sample_count = win_count[10:0];
    if (win_count == 0) return s;
    if (extremes_dirty) rebuild_extremes();
    newest = win_period[ring_slot(win_count - 1)];
    s.current_fps    = 28'(round_div(FpsScale, newest));
    s.current_period = newest;
    s.min_fps        = 28'(round_div(FpsScale, longest_period));
    s.max_fps        = 28'(round_div(FpsScale, shortest_period));
    s.average_fps    = 28'(round_div(win_count * FpsScale, period_sum));
    s.jitter         = (win_count < 2) ? '0 : 24'(round_div(change_sum, win_count - 1));
    return s;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch at summary %0d: %s got %0d expected %0d",
             summaries_seen, field, got, want);
    mismatches++;
  endtask

  // Sends one frame event and records its expected summary on acceptance
  task automatic send_event(bit op, logic [47:0] ts, logic [23:0] p);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    timestamp_us_i <= ts;
    period_us_i    <= p;
    do @(posedge clk_i); while (!in_ready_o);
    pending_stats.push_back(window_summary(op, ts, p));
  endtask

  task automatic record_at(logic [47:0] ts, logic [23:0] p);
    now_us = ts;
    send_event(OpRecord, ts, p);
  endtask

  // Register writes only with the core drained
  task automatic set_window(logic [31:0] len);
    in_valid_i <= 1'b0;
    wait (pending_stats.size() == 0);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_len = len;
  endtask

  task automatic test_directed();
    send_event(OpRecord, 48'd0, 24'd100);        // zero-period check comes next
    send_event(OpRecord, 48'd5, 24'd0);          // zero period with one sample held
    send_event(OpClear, 48'd5, 24'd1000);        // clear with one sample held
    record_at(48'd10, 24'd1);                    // shortest period
    record_at(48'd20, 24'hFFFFFF);               // longest period
    send_event(OpRecord, 48'd25, 24'd0);         // zero period with samples held
    record_at(48'd30, 24'd16667);
    record_at(48'd40, 24'd33333);
    record_at(48'd35, 24'd20000);                // timestamp going backwards
    send_event(OpClear, 48'd40, 24'd0);          // clear with samples held
    record_at(48'hFFFF_FFFF_FFF0, 24'd500);
    record_at(48'hFFFF_FFFF_FFFF, 24'd700);      // largest timestamp
    send_event(OpClear, 48'd0, 24'd0);
    set_window(32'd1);                           // shortest window
    record_at(48'd100, 24'd300);
    record_at(48'd101, 24'd100);                 // age 1 is kept
    record_at(48'd102, 24'd200);                 // evicts the longest: rescan
    record_at(48'd103, 24'd400);                 // evicts the shortest
    record_at(48'd200, 24'd250);                 // all older samples age out
    record_at(48'd200, 24'd251);
    set_window(32'hFFFF_FFFF);                   // longest window
    record_at(48'd300, 24'd800);
    record_at(48'h0001_0000_0000, 24'd900);      // age just under the 32-bit window is kept
    send_event(OpClear, now_us, 24'd0);
  endtask

  // Fills the ring past its depth so the oldest sample gets pushed out
  task automatic test_ring_overflow();
    set_window(32'hFFFF_FFFF);
    no_gaps = 1'b1;
    send_event(OpClear, now_us, 24'd0);
    for (int unsigned i = 0; i < Depth + 12; i++)
      record_at(now_us + 1, 24'(2000 + (i * 37) % 5000));
    record_at(now_us + 1, 24'd1);                // new extreme in a full ring
    no_gaps = 1'b0;
    send_event(OpClear, now_us, 24'd0);
  endtask

  // Random frame events at one window setting; step bounds the time advance
  task automatic test_random_phase(logic [31:0] len, int unsigned items,
                                   int unsigned step);
    logic [23:0] p;
    logic [47:0] ts;
    set_window(len);
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 24) == 0) begin
        send_event(OpClear, 48'({$urandom, $urandom}), 24'($urandom));
      end else begin
        case ($urandom_range(0, 11))
          0:       p = '0;
          1, 2:    p = 24'($urandom);
          default: p = 24'($urandom_range(1000, 100000));
        endcase
        ts = now_us + $urandom_range(0, step);
        if ($urandom_range(0, 39) == 0) ts = 48'({$urandom, $urandom});
        now_us = ts;
        send_event(OpRecord, ts, p);
      end
    end
    no_gaps = 1'b0;
  endtask

  // Result side: random stall before each transfer, none while no_gaps is set
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      summaries_seen++;
      if (pending_stats.size() == 0) begin
        $display("unexpected summary %0d with none pending", summaries_seen);
        mismatches++;
      end else begin
        frame_stats_t want;
        want = pending_stats.pop_front();
        if (accepted_o != want.accepted) report_mismatch("accepted", accepted_o, want.accepted);
        if (overflow_o != want.overflow) report_mismatch("overflow", overflow_o, want.overflow);
        if (overflow_o) overflows_seen++;
        if (sample_count_o != want.sample_count)
          report_mismatch("sample_count", sample_count_o, want.sample_count);
        if (current_fps_q8_o != want.current_fps)
          report_mismatch("current_fps_q8", current_fps_q8_o, want.current_fps);
        if (current_period_out_us_o != want.current_period)
          report_mismatch("current_period_out_us", current_period_out_us_o,
                          want.current_period);
        if (min_fps_q8_o != want.min_fps)
          report_mismatch("min_fps_q8", min_fps_q8_o, want.min_fps);
        if (max_fps_q8_o != want.max_fps)
          report_mismatch("max_fps_q8", max_fps_q8_o, want.max_fps);
        if (average_fps_q8_o != want.average_fps)
          report_mismatch("average_fps_q8", average_fps_q8_o, want.average_fps);
        if (jitter_us_o != want.jitter) report_mismatch("jitter_us", jitter_us_o, want.jitter);
      end
      ready_hold = no_gaps ? 0 : $urandom_range(0, 18);
    end
    if (ready_hold != 0) begin
      out_ready_i <= 1'b0;
      ready_hold--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d summaries pending",
               cycle_count, pending_stats.size());
      $display("tb_sliding_window_frame_time_stats_core NOT OK");
      $finish;
    end
  end

  initial begin
    win_head = 0;
    window_len = WindowReset;
    window_reset_sums();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_ring_overflow();
    test_random_phase(32'd1, 120, 3);
    test_random_phase(32'hFFFF_FFFF, 130, 50000);
    test_random_phase($urandom_range(50, 2000), 150, 400);
    test_random_phase($urandom_range(100000, 2000000), 150, 60000);
    test_random_phase(WindowReset, 100, 200000);

    in_valid_i <= 1'b0;
    wait (pending_stats.size() == 0);
    repeat (400) @(posedge clk_i);

    $display("checked %0d summaries: %0d ring overflows, %0d extreme rebuilds,",
             summaries_seen, overflows_seen, rescans_done);
    $display("window lengths from 1 us to the 32-bit maximum, clears and zero periods mixed in");
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("tb_sliding_window_frame_time_stats_core OK");
    end else begin
      $display("tb_sliding_window_frame_time_stats_core NOT OK");
    end
    $finish;
  end
endmodule

>>> sliding_window_frame_time_stats_core.f
hw/rtl/swfts_pkg.sv
hw/rtl/swfts_div.sv
hw/rtl/sliding_window_frame_time_stats_core.sv
test/tb_sliding_window_frame_time_stats_core.sv
